// ----- rtl/core/positional_list_engine_top_macros.svh -----
// Assertion macros used by the list engine RTL.
`ifndef POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define PLIST_ASSERT_RST(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is checked at every edge, reset included.
`define PLIST_ASSERT(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/plist_pkg.sv -----
// Shared constants, codes and control structs of the positional list engine.
`timescale 1ns / 1ps
package plist_pkg;

	localparam int CAPACITY = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int POS_W    = 7;
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 7;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    capture;
		logic    wr_insert;
		logic    wr_remove;
		logic    wr_clear;
		logic    sel_data;
		status_t res_status;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic pos_gt_cnt;
		logic pos_ge_cnt;
		logic full;
	} dp_stat_t;

endpackage

// ----- rtl/core/positional_list_engine_top.sv -----
// Top level of the positional list engine.
//
// Keeps an ordered list of up to 64 signed 32-bit words. A request word is taken at a
// rising edge with start high and busy low, into the request register. busy then stays
// high during the execute cycle, in which the row of entry registers shifts the
// whole tail at once. The result word appears on status, data, count and is_empty in
// the cycle after that, for exactly one cycle with done high. There is no way to stall
// the result: it must be taken in that cycle. busy is already low during the done
// cycle, so a new request can be issued in the cycle that shows the last result.
`timescale 1ns / 1ps
module positional_list_engine_top import plist_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] value,
	output logic                     done,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic [COUNT_W-1:0]       count,
	output logic                     is_empty
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	plist_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	plist_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.opcode   (opcode),
		.position (position),
		.value    (value),
		.stat     (stat),
		.status   (status),
		.data     (data),
		.count    (count),
		.is_empty (is_empty)
	);

endmodule

// ----- rtl/core/plist_ctrl.sv -----
// Controller of the list engine: request sequencing and result decode.
`timescale 1ns / 1ps
module plist_ctrl import plist_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   done_q;

	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.capture = 1'b1;
				state_d     = S_IDLE;
				case (stat.op)
					OP_INSERT: begin
						// A bad position wins over a full list.
						if (stat.pos_gt_cnt) begin
							cmd.res_status = ST_BADPOS;
						end else if (stat.full) begin
							cmd.res_status = ST_FULL;
						end else begin
							cmd.wr_insert = 1'b1;
						end
					end
					OP_REMOVE, OP_READ: begin
						// An empty list is reported before the position is checked.
						if (stat.cnt_zero) begin
							cmd.res_status = ST_EMPTY;
						end else if (stat.pos_ge_cnt) begin
							cmd.res_status = ST_BADPOS;
						end else begin
							cmd.sel_data  = 1'b1;
							cmd.wr_remove = (stat.op == OP_REMOVE);
						end
					end
					OP_CLEAR: begin
						cmd.wr_clear = 1'b1;
					end
					default: begin
						cmd.wr_clear = 1'b0;
					end
				endcase
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_EXEC);
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

// ----- rtl/core/plist_dp.sv -----
// Datapath of the list engine: request register, shifting entry row and result register.
`timescale 1ns / 1ps
`include "positional_list_engine_top_macros.svh"
module plist_dp import plist_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	input  logic [1:0]               opcode,
	input  logic [POS_W-1:0]         position,
	input  logic signed [WORD_W-1:0] value,
	output dp_stat_t                 stat,
	output logic [1:0]               status,
	output logic signed [WORD_W-1:0] data,
	output logic [COUNT_W-1:0]       count,
	output logic                     is_empty
);

	op_t                      op_q;
	logic [POS_W-1:0]         pos_q;
	logic signed [WORD_W-1:0] val_q;
	logic [CNT_W-1:0]         cnt_q;
	status_t                  status_q;
	logic signed [WORD_W-1:0] data_q;
	logic signed [WORD_W-1:0] entries_q [CAPACITY];

	logic [CMP_W-1:0]         pos_ext;
	logic [CMP_W-1:0]         cnt_ext;
	logic signed [WORD_W-1:0] rd_word;

	assign pos_ext = CMP_W'(pos_q);
	assign cnt_ext = CMP_W'(cnt_q);
	assign rd_word = entries_q[IDX_W'(pos_q)];

	assign stat.op         = op_q;
	assign stat.cnt_zero   = (cnt_q == '0);
	assign stat.pos_gt_cnt = (pos_ext > cnt_ext);
	assign stat.pos_ge_cnt = (pos_ext >= cnt_ext);
	assign stat.full       = (cnt_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(opcode);
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.capture) begin
			status_q <= cmd.res_status;
			data_q   <= cmd.sel_data ? rd_word : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.wr_clear) begin
			cnt_q <= '0;
		end else if (cmd.wr_insert) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else if (cmd.wr_remove) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Every cell looks only at its two neighbors and the request value, so an insert or
	// remove moves the whole tail of the list at once.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		localparam logic [CMP_W-1:0] CELL = CMP_W'(g);
		logic signed [WORD_W-1:0] up_word;
		logic signed [WORD_W-1:0] down_word;

		if (g < CAPACITY - 1) begin : g_up
			assign up_word = entries_q[g + 1];
		end else begin : g_last
			assign up_word = entries_q[g];
		end

		if (g > 0) begin : g_down
			assign down_word = entries_q[g - 1];
		end else begin : g_first
			assign down_word = entries_q[g];
		end

		always_ff @(posedge clk) begin
			if (cmd.wr_insert) begin
				if (CELL == pos_ext) begin
					entries_q[g] <= val_q;
				end else if (CELL > pos_ext) begin
					entries_q[g] <= down_word;
				end
			end else if (cmd.wr_remove && (CELL >= pos_ext)) begin
				entries_q[g] <= up_word;
			end
		end
	end

	assign status   = status_q;
	assign data     = data_q;
	assign count    = COUNT_W'(cnt_q);
	assign is_empty = (cnt_q == '0);

	`PLIST_ASSERT_RST(a_insert_grows, clk, arst_n, cmd.wr_insert |=> cnt_q == $past(cnt_q) + CNT_W'(1), "insert did not grow the list by one")
	`PLIST_ASSERT_RST(a_remove_shrinks, clk, arst_n, cmd.wr_remove |=> cnt_q == $past(cnt_q) - CNT_W'(1), "remove did not shrink the list by one")
	`PLIST_ASSERT_RST(a_insert_legal, clk, arst_n, cmd.wr_insert |-> !stat.full && !stat.pos_gt_cnt, "insert issued on a full list or at a bad position")
	`PLIST_ASSERT_RST(a_fail_zero_data, clk, arst_n, cmd.capture && cmd.res_status != ST_OK |=> data_q == '0, "failed request returned nonzero data")

endmodule

// ----- test/tb_positional_list_engine_top.sv -----
// Self-checking testbench for the positional list engine top level.
`timescale 1ns / 1ps
module tb_positional_list_engine_top;
	import plist_pkg::*;

	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   data;
		logic [COUNT_W-1:0]  count;
		logic                is_empty;
	} list_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [1:0]               opcode;
	logic [POS_W-1:0]         position;
	logic signed [WORD_W-1:0] value;
	logic                     done;
	logic [1:0]               status;
	logic signed [WORD_W-1:0] data;
	logic [COUNT_W-1:0]       count;
	logic                     is_empty;

	// Shadow copy of the list, updated when a request word is accepted.
	logic [WORD_W-1:0] list_mem [CAPACITY];
	int                list_len;

	list_result_t expected_results [$];
	list_result_t want_word;
	int           failures;
	int           max_gap;

	positional_list_engine_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.opcode   (opcode),
		.position (position),
		.value    (value),
		.done     (done),
		.status   (status),
		.data     (data),
		.count    (count),
		.is_empty (is_empty)
	);

	always #5 clk = ~clk;

	function automatic list_result_t apply_list_op(input op_t op, input int pos,
			input logic [WORD_W-1:0] val);
		list_result_t r;
		int           i;
		r.status = ST_OK;
		r.data   = '0;
		case (op)
			OP_INSERT: begin
				// A bad position wins over a full list.
				if (pos > list_len) begin
					r.status = ST_BADPOS;
				end else if (list_len >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					for (i = list_len; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_len++;
				end
			end
			OP_REMOVE, OP_READ: begin
				// An empty list is reported before the position is looked at.
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else if (pos >= list_len) begin
					r.status = ST_BADPOS;
				end else begin
					r.data = list_mem[pos];
					if (op == OP_REMOVE) begin
						for (i = pos; i + 1 < list_len; i++)
							list_mem[i] = list_mem[i+1];
						list_len--;
					end
				end
			end
			default: begin
				list_len = 0;
			end
		endcase
		r.count    = list_len[COUNT_W-1:0];
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	task automatic send_word(input op_t op, input int pos, input logic [WORD_W-1:0] val);
		int gap;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start    <= 1'b1;
		opcode   <= op;
		position <= pos[POS_W-1:0];
		value    <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_results.push_back(apply_list_op(op, pos, val));
	endtask

	task automatic wait_results_drained();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// Mostly a position inside [0, hi], now and then any 7-bit position; always any when hi < 0.
	function automatic int pick_pos(input int hi);
		if ($urandom_range(0, 9) == 0 || hi < 0)
			return $urandom_range(0, (1 << POS_W) - 1);
		return $urandom_range(0, hi);
	endfunction

	task automatic test_directed_corners();
		max_gap = 9;
		send_word(OP_READ, 0, $urandom);
		send_word(OP_REMOVE, 0, $urandom);
		send_word(OP_REMOVE, 127, $urandom);
		send_word(OP_INSERT, 1, $urandom);
		send_word(OP_INSERT, 127, $urandom);
		send_word(OP_CLEAR, 0, $urandom);
		send_word(OP_INSERT, 0, 32'h7FFF_FFFF);
		send_word(OP_INSERT, 1, 32'h8000_0000);
		send_word(OP_INSERT, 0, 32'h0000_0000);
		send_word(OP_INSERT, 1, 32'hFFFF_FFFF);
		for (int i = 0; i < 4; i++)
			send_word(OP_READ, i, $urandom);
		send_word(OP_READ, 4, $urandom);
		send_word(OP_READ, 127, $urandom);
		send_word(OP_INSERT, 5, $urandom);
		send_word(OP_REMOVE, 4, $urandom);
		send_word(OP_REMOVE, 1, $urandom);
		send_word(OP_REMOVE, 2, $urandom);
		send_word(OP_REMOVE, 0, $urandom);
		send_word(OP_READ, 0, $urandom);
		send_word(OP_CLEAR, 127, $urandom);
		send_word(OP_READ, 0, $urandom);
	endtask

	task automatic test_fill_and_overflow();
		max_gap = 3;
		send_word(OP_CLEAR, 0, $urandom);
		while (list_len < CAPACITY)
			send_word(OP_INSERT, $urandom_range(0, list_len), $urandom);
		send_word(OP_INSERT, CAPACITY, $urandom);
		send_word(OP_INSERT, 0, $urandom);
		send_word(OP_INSERT, CAPACITY + 1, $urandom);
		send_word(OP_INSERT, 127, $urandom);
		send_word(OP_READ, CAPACITY - 1, $urandom);
		send_word(OP_READ, CAPACITY, $urandom);
		send_word(OP_REMOVE, CAPACITY, $urandom);
		send_word(OP_REMOVE, CAPACITY - 1, $urandom);
		send_word(OP_INSERT, CAPACITY - 1, $urandom);
		while (list_len > 0) begin
			if ($urandom_range(0, 3) == 0)
				send_word(OP_READ, $urandom_range(0, list_len - 1), $urandom);
			send_word(OP_REMOVE, $urandom_range(0, list_len - 1), $urandom);
		end
		send_word(OP_REMOVE, 0, $urandom);
	endtask

	task automatic test_pause_until_drained();
		max_gap = 0;
		for (int i = 0; i < 5; i++)
			send_word(OP_INSERT, $urandom_range(0, list_len), $urandom);
		wait_results_drained();
		send_word(OP_READ, $urandom_range(0, list_len - 1), $urandom);
		send_word(OP_REMOVE, 0, $urandom);
		wait_results_drained();
	endtask

	task automatic test_random_mix();
		int ins_pct;
		int r;
		for (int seg = 0; seg < 9; seg++) begin
			case (seg)
				0, 4:    ins_pct = 95;
				1, 6:    ins_pct = 80;
				2, 7:    ins_pct = 50;
				default: ins_pct = 25;
			endcase
			if (seg == 0)
				max_gap = 0;
			else if (seg == 1)
				max_gap = 9;
			else
				max_gap = ($urandom_range(0, 2) == 0) ? 0 : 9;
			for (int n = 0; n < 80; n++) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					send_word(OP_CLEAR, pick_pos(-1), $urandom);
				else if (r < 2 + ins_pct)
					send_word(OP_INSERT, pick_pos(list_len), $urandom);
				else if (r[0])
					send_word(OP_REMOVE, pick_pos(list_len - 1), $urandom);
				else
					send_word(OP_READ, pick_pos(list_len - 1), $urandom);
			end
			if (seg % 3 == 2)
				wait_results_drained();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result word with nothing pending: status %0d data %h count %0d empty %0b",
					$time, status, data, count, is_empty);
				failures++;
			end else begin
				want_word = expected_results.pop_front();
				if ({status, data, count, is_empty} !== want_word) begin
					$display("%0t: mismatch, expected status %0d data %h count %0d empty %0b",
						$time, want_word.status, want_word.data, want_word.count,
						want_word.is_empty);
					$display("%0t:            actual status %0d data %h count %0d empty %0b",
						$time, status, data, count, is_empty);
					failures++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("positional_list_engine_top regression: fail");
		$finish;
	end

	initial begin
		failures = 0;
		list_len = 0;
		max_gap  = 0;
		arst_n   <= 1'b0;
		start    <= 1'b0;
		opcode   <= OP_INSERT;
		position <= '0;
		value    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_corners();
		test_fill_and_overflow();
		test_pause_until_drained();
		test_random_mix();
		start <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("positional_list_engine_top regression: pass");
		else
			$display("positional_list_engine_top regression: fail");
		$finish;
	end

endmodule
